// File: hdl/lzsr_pkg.sv
// Shared constants and types for the longest zero-sum run block.
package lzsr_pkg;

	// Longest sequence that is tracked, and the significant bits of an element
	localparam int MAX_LEN    = 256;
	localparam int VALUE_BITS = 16;

	// Field and state widths
	localparam int IN_W  = 16;
	localparam int SUM_W = 24;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);

	// Write beat into the prefix-sum cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] idx;
	} cam_wr_t;

	// Lookup answer from the prefix-sum cells
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} cam_hit_t;

endpackage

// File: hdl/lzsr_cam.sv
// Associative table of first-seen prefix sums: one cell per entry, parallel match.
module lzsr_cam import lzsr_pkg::*; (
	input  logic             clk,
	input  cam_wr_t          wr,
	input  logic [LEN_W-1:0] fill,
	input  logic [SUM_W-1:0] key,
	output cam_hit_t         rd
);

	logic [SUM_W-1:0]   sum_q [MAX_LEN];
	logic [IDX_W-1:0]   idx_q [MAX_LEN];
	logic [MAX_LEN-1:0] match;
	logic [IDX_W-1:0]   idx_or;

	// Cell write, entries are only meaningful below the fill count
	always_ff @(posedge clk) begin
		if (wr.en) begin
			sum_q[wr.addr] <= wr.sum;
			idx_q[wr.addr] <= wr.idx;
		end
	end

	// Per-cell compare; stored sums are unique so at most one cell matches
	always_comb begin
		idx_or = '0;
		for (int k = 0; k < MAX_LEN; k++) begin
			match[k] = (LEN_W'(k) < fill) && (sum_q[k] == key);
			idx_or   = idx_or | (idx_q[k] & {IDX_W{match[k]}});
		end
	end

	assign rd.hit = |match;
	assign rd.idx = idx_or;

endmodule

// File: hdl/longest_zero_sum_run.sv
// Longest zero-sum contiguous run: input register, table match, result register.
//
// Takes one signed element per beat and returns one result per beat: the longest
// contiguous run of zero sum seen so far in the current sequence, a done flag for
// the beat marked last, and an overflow flag once more than MAX_LEN (256) elements
// arrived in one sequence (those extra elements are ignored). A new element is
// accepted every cycle unless the input is stalled; its result passes through the
// input stage, then the result register, before it is presented. A stalled result
// holds the result register, and with the input stage full it stalls the input.
// The cycle time is set by the 256-cell parallel compare of the running prefix
// sum against the table of first-seen sums. After the beat marked last all state
// returns to its reset values. No clearing pass is needed after reset: table
// entries are qualified by a fill count.
module longest_zero_sum_run import lzsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [IN_W-1:0]  value,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [LEN_W-1:0] best_length,
	output logic             done_res,
	output logic             overflow
);

	// Front state
	logic [SUM_W-1:0] running_sum_q;
	logic [LEN_W-1:0] item_count_q;
	logic             overflow_q;

	// Input stage
	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             skip_s1;
	logic             last_s1;
	logic             ovf_s1;

	// Back state
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] best_q;

	logic             accept;
	logic             advance;
	logic             ignore_in;
	logic [SUM_W-1:0] sum_next;
	logic [LEN_W-1:0] cand;
	logic [LEN_W-1:0] best_next;
	logic             insert;
	cam_wr_t          cam_wr;
	cam_hit_t         cam_rd;

	// Handshake
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Prefix sum update, element sign-extended from its significant bits
	assign ignore_in = item_count_q >= LEN_W'(MAX_LEN);
	assign sum_next  = running_sum_q + SUM_W'(signed'(value[VALUE_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			item_count_q  <= '0;
			overflow_q    <= 1'b0;
		end else if (accept) begin
			if (last) begin
				running_sum_q <= '0;
				item_count_q  <= '0;
				overflow_q    <= 1'b0;
			end else if (ignore_in) begin
				overflow_q <= 1'b1;
			end else begin
				running_sum_q <= sum_next;
				item_count_q  <= item_count_q + LEN_W'(1);
			end
		end
	end

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= sum_next;
			idx_s1  <= item_count_q[IDX_W-1:0];
			skip_s1 <= ignore_in;
			last_s1 <= last;
			ovf_s1  <= overflow_q | ignore_in;
		end
	end

	// First-seen table
	assign cam_wr.en   = advance && insert;
	assign cam_wr.addr = fill_q[IDX_W-1:0];
	assign cam_wr.sum  = sum_s1;
	assign cam_wr.idx  = idx_s1;

	lzsr_cam u_cam (
		.clk  (clk),
		.wr   (cam_wr),
		.fill (fill_q),
		.key  (sum_s1),
		.rd   (cam_rd)
	);

	// Candidate length and best update
	always_comb begin
		cand   = '0;
		insert = 1'b0;
		if (cam_rd.hit) begin
			cand = LEN_W'(idx_s1 - cam_rd.idx);
		end else if (sum_s1 == '0) begin
			cand = LEN_W'(idx_s1) + LEN_W'(1);
		end else begin
			insert = !skip_s1 && (fill_q < LEN_W'(MAX_LEN));
		end
		if (skip_s1 || cand <= best_q) begin
			best_next = best_q;
		end else begin
			best_next = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			best_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				fill_q <= '0;
				best_q <= '0;
			end else begin
				best_q <= best_next;
				if (insert) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			best_length <= best_next;
			done_res    <= last_s1;
			overflow    <= ovf_s1;
		end
	end

	// Zero sums are never stored, so they never match
	a_no_zero_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cam_rd.hit) |-> (sum_s1 != '0))
		else $error("table matched a zero prefix sum");

	// A matched first index always lies before the current index
	a_hit_earlier: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !skip_s1 && cam_rd.hit) |-> (cam_rd.idx < idx_s1))
		else $error("matched first index not earlier than current index");

	// Fill count bounded by the table depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_LEN))
		else $error("fill count beyond table depth");

	// Sequence end clears the back state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (fill_q == '0 && best_q == '0))
		else $error("state not cleared after last beat");

endmodule

// File: sim/longest_zero_sum_run_tb.sv
// Self-checking testbench for the longest zero-sum run block.
`timescale 1ns / 100ps

module longest_zero_sum_run_tb;
	import lzsr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int STIM_ITEMS  = 1800;

	typedef struct packed {
		logic [IN_W-1:0] elem;
		logic            is_last;
		logic            drain;
	} run_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] best_length;
		logic             done_res;
		logic             overflow;
	} run_result_t;

	typedef enum int {SEQ_SMALL, SEQ_FULL, SEQ_PLANTED, SEQ_RAMP} seq_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [IN_W-1:0]  value     = '0;
	logic             last      = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [LEN_W-1:0] best_length;
	logic             done_res;
	logic             overflow;

	run_item_t   stim_q[$];
	run_result_t results_due[$];
	int          errors = 0;
	int          cycles = 0;

	// Predicted run state
	logic [SUM_W-1:0] run_sum    = '0;
	int               seq_count  = 0;
	int               best_run   = 0;
	int               fill       = 0;
	logic             seq_overflow = 1'b0;
	logic [SUM_W-1:0] seen_sum [MAX_LEN];
	int               seen_idx [MAX_LEN];

	longest_zero_sum_run u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_length(best_length),
		.done_res   (done_res),
		.overflow   (overflow)
	);

	always #5 clk = ~clk;

	// Advance the run state by one element and queue the expected result
	task automatic update_run_state(input logic [IN_W-1:0] v, input logic lst);
		int  cand;
		bit  hit;
		if (seq_count >= MAX_LEN) begin
			seq_overflow = 1'b1;
		end else begin
			run_sum = run_sum + {{(SUM_W-IN_W){v[IN_W-1]}}, v};
			cand = 0;
			hit  = 1'b0;
			// first-seen index only; later repeats never overwrite
			for (int k = 0; k < fill; k++) begin
				if (!hit && seen_sum[k] == run_sum) begin
					hit  = 1'b1;
					cand = seq_count - seen_idx[k];
				end
			end
			if (!hit) begin
				if (run_sum == '0) begin
					cand = seq_count + 1;
				end else if (fill < MAX_LEN) begin
					seen_sum[fill] = run_sum;
					seen_idx[fill] = seq_count;
					fill++;
				end
			end
			if (cand > best_run)
				best_run = cand;
			seq_count++;
		end
		results_due.push_back('{best_length: best_run[LEN_W-1:0], done_res: lst,
			overflow: seq_overflow});
		if (lst) begin
			run_sum      = '0;
			seq_count    = 0;
			best_run     = 0;
			fill         = 0;
			seq_overflow = 1'b0;
		end
	endtask

	task automatic add_item(input int v, input bit lst, input bit drn);
		stim_q.push_back('{elem: v[IN_W-1:0], is_last: lst, drain: drn});
	endtask

	// One sequence ending in a last beat; planted values sometimes return the sum to an earlier prefix
	task automatic gen_sequence(input int len, input seq_kind_t kind, input bit drn);
		int s;
		int v;
		int target;
		int pre[$];
		s = 0;
		pre.push_back(0);
		for (int i = 0; i < len; i++) begin
			case (kind)
				SEQ_SMALL: v = int'($urandom_range(0, 6)) - 3;
				SEQ_FULL:  v = int'($urandom_range(0, 65535)) - 32768;
				SEQ_PLANTED: begin
					target = pre[$urandom_range(0, pre.size() - 1)];
					v = target - s;
					if ($urandom_range(0, 2) != 0 || v < -32768 || v > 32767)
						v = int'($urandom_range(0, 200)) - 100;
				end
				default: v = 1;
			endcase
			s += v;
			pre.push_back(s);
			add_item(v, i == len - 1, drn && i == 0);
		end
	endtask

	// Stimulus and end of run
	initial begin
		seq_kind_t kind;
		int        len;

		// zero element alone
		add_item(0, 1, 0);
		// repeated sum keeps the first index, extremes in the middle
		add_item(5, 0, 0);
		add_item(7, 0, 0);
		add_item(-7, 0, 0);
		add_item(-32768, 0, 0);
		add_item(32767, 0, 0);
		add_item(1, 1, 0);
		// extremes back to a zero prefix; wait for the pipe to empty first
		add_item(-32768, 0, 1);
		add_item(-32768, 0, 0);
		add_item(32767, 0, 0);
		add_item(32767, 0, 0);
		add_item(2, 1, 0);
		// nested zero runs
		add_item(32767, 0, 0);
		add_item(-32767, 0, 0);
		add_item(-1, 0, 0);
		add_item(1, 1, 0);
		// nonzero single element
		add_item(-1, 1, 0);

		// overflow: full table of distinct sums, then ignored beats incl. the last one
		gen_sequence(270, SEQ_RAMP, 1'b0);
		gen_sequence(262, SEQ_PLANTED, 1'b1);

		while (stim_q.size() < STIM_ITEMS) begin
			kind = seq_kind_t'($urandom_range(0, 2));
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
			gen_sequence(len, kind, $urandom_range(0, 19) == 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Input driver: bursts with random gaps, optional pause until results drain
	int   burst_left = 1;
	int   gap_left   = 0;
	logic took;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (in_valid && !took) begin
				// stalled beat holds
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (stim_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (stim_q[0].drain && (took || results_due.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				value    <= stim_q[0].elem;
				last     <= stim_q[0].is_last;
				in_valid <= 1'b1;
				void'(stim_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
						: $urandom_range(0, 3);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Result-side stall pattern: modes held for random stretches
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
				STALL_PERIODIC: out_stall <= (cycles[1:0] != 2'd0);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	// Predict on accepted input beats, check accepted result beats
	run_result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				update_run_state(value, last);
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: best_length=%0d done_res=%0b overflow=%0b",
						best_length, done_res, overflow);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (best_length !== want.best_length) begin
						$error("best_length: expected %0d, got %0d", want.best_length, best_length);
						errors++;
					end
					if (done_res !== want.done_res) begin
						$error("done_res: expected %0b, got %0b", want.done_res, done_res);
						errors++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, overflow);
						errors++;
					end
				end
			end
		end
	end

endmodule
